/* src/spn_cipher_32bit_encrypt_unit_assert.svh */
// ---------------------------------------------------------------------------
// SPN cipher assertion macros
// Short forms for the concurrent checks used in the encrypt unit.
// ---------------------------------------------------------------------------
`ifndef SPN_CIPHER_32BIT_ENCRYPT_UNIT_ASSERT_SVH
`define SPN_CIPHER_32BIT_ENCRYPT_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define SPN_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spn assertion failed");

// next-cycle implication, off during reset
`define SPN_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spn assertion failed");

// checks what reset itself leaves behind
`define SPN_ASSERT_AFTER_RESET(name, clk, rst, cons) \
   name: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("spn assertion failed");

`endif

/* src/spn_pkg.sv */
// ---------------------------------------------------------------------------
// SPN cipher package
// Round shift table, nibble table and the round functions.
// ---------------------------------------------------------------------------
package spn_pkg;

   localparam int WORD_WIDTH    = 32;
   localparam int ROUND_DEFAULT = 16;
   localparam int PRIME_COUNT   = 23;

   typedef logic [WORD_WIDTH-1:0] word_type;

   localparam logic [6:0] ROUND_PRIMES [PRIME_COUNT] = '{
      7'd5,  7'd7,  7'd11, 7'd13, 7'd17, 7'd19, 7'd23, 7'd29,
      7'd31, 7'd37, 7'd41, 7'd43, 7'd47, 7'd53, 7'd59, 7'd61,
      7'd67, 7'd71, 7'd73, 7'd79, 7'd83, 7'd89, 7'd97
   };

   localparam word_type NIBBLE_TABLE [16] = '{
      32'h673b2a77, 32'h514af6b1, 32'hb2cf4e6f, 32'hdc958843,
      32'h20d0a204, 32'h95786052, 32'h795c3fe5, 32'he8b3e72c,
      32'haef914fe, 32'h4d227ba0, 32'h3fe70c96, 32'hf48693db,
      32'h0a6dbd1a, 32'hcb01c1cd, 32'h13a4d988, 32'h861e5539
   };

   // rotate right, amount already reduced to 5 bits
   function automatic word_type rotr32(input word_type v, input logic [4:0] s);
      logic [2*WORD_WIDTH-1:0] dbl;
      dbl = {v, v} >> s;
      return dbl[WORD_WIDTH-1:0];
   endfunction

   function automatic word_type substitute(input word_type v);
      word_type r;
      word_type e;
      r = '0;
      for (int j = 0; j < 8; j++) begin
         e = NIBBLE_TABLE[v[4*j +: 4]];
         r[4*j +: 4] = e[4*j +: 4];
      end
      return r;
   endfunction

   function automatic word_type permute(input word_type v);
      return (v & 32'h11111111) |
             ((v & 32'h20200000) >> 2)  |
             ((v & 32'h08080800) << 2)  |
             ((v & 32'h04040000) >> 4)  |
             ((v & 32'h00004000) << 4)  |
             ((v & 32'h00000020) << 5)  |
             ((v & 32'h40000000) >> 7)  |
             ((v & 32'h00008200) >> 8)  |
             ((v & 32'h00800002) << 8)  |
             ((v & 32'h00020000) >> 15) |
             ((v & 32'h00000004) << 15) |
             ((v & 32'h80400000) >> 16) |
             ((v & 32'h00000080) << 19) |
             ((v & 32'h02000000) >> 22) |
             ((v & 32'h00000008) << 22) |
             ((v & 32'h00000040) << 24);
   endfunction

endpackage

/* src/spn_cipher_32bit_encrypt_unit.sv */
// ---------------------------------------------------------------------------
// SPN cipher 32-bit encrypt unit
// Pipelined substitution-permutation encryptor, one round per stage.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  req_      in         req_tvalid/req_tready  tdata[31:0] plaintext
//  rsp_      out        rsp_tvalid/rsp_tready  tdata[31:0] ciphertext
//  csr_      in         csr_valid/csr_ready    csr_data[31:0] cipher_key
//
//  One item per cycle sustained while rsp_tready is high; each result passes
//  through one register stage per round before rsp_tvalid rises.
//  Synchronous active-high reset empties every stage and clears the key;
//  req_tready and csr_ready stay low while reset is high.
//  A stall at rsp_ holds the last stage; earlier stages keep filling into
//  empty slots, so bubbles close up before req_tready drops.
//  csr_ready is high out of reset; the user must write the key only while the
//  pipe is empty; the block itself does not enforce this.
module spn_cipher_32bit_encrypt_unit #(
   parameter int ROUND_COUNT = spn_pkg::ROUND_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // item in
   input  logic              req_tvalid,
   output logic              req_tready,
   input  spn_pkg::word_type req_tdata,   // [31:0] plaintext
   // item out
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output spn_pkg::word_type rsp_tdata,   // [31:0] ciphertext
   // key register write
   input  logic              csr_valid,
   output logic              csr_ready,
   input  spn_pkg::word_type csr_data     // [31:0] cipher_key
);
   import spn_pkg::*;

   `include "spn_cipher_32bit_encrypt_unit_assert.svh"

   // key register
   word_type key_ff;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_valid) begin
         key_ff <= csr_data;
      end
   end

   // pipeline stages: stage i holds the word after round i
   logic     valid_ff    [ROUND_COUNT];
   word_type word_ff     [ROUND_COUNT];
   logic     stage_ready [ROUND_COUNT];

   genvar gi;
   generate
      for (gi = 0; gi < ROUND_COUNT; gi++) begin : g_round
         // rotate amount is a constant per stage, so the rotate is wiring
         localparam logic [6:0] PRIME = ROUND_PRIMES[gi % PRIME_COUNT];

         logic     up_valid;
         word_type up_word;
         logic     down_ready;
         word_type round_key;
         word_type word_in;
         logic     valid_in;

         if (gi == 0) begin : g_first
            assign up_valid = req_tvalid;
            assign up_word  = req_tdata;
         end else begin : g_mid
            assign up_valid = valid_ff[gi-1];
            assign up_word  = word_ff[gi-1];
         end

         if (gi == ROUND_COUNT-1) begin : g_last
            assign down_ready = rsp_tready;
         end else begin : g_inner
            assign down_ready = stage_ready[gi+1];
         end

         assign stage_ready[gi] = !valid_ff[gi] || down_ready;
         assign round_key       = rotr32(key_ff, PRIME[4:0]);
         assign word_in         = permute(substitute(up_word ^ round_key));
         assign valid_in        = stage_ready[gi] ? up_valid : valid_ff[gi];

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[gi] <= 1'b0;
            end else begin
               valid_ff[gi] <= valid_in;
            end
         end

         // payload needs no reset
         always_ff @(posedge clock) begin
            if (stage_ready[gi] && up_valid) begin
               word_ff[gi] <= word_in;
            end
         end
      end
   endgenerate

   assign req_tready = stage_ready[0] && !reset;
   assign rsp_tvalid = valid_ff[ROUND_COUNT-1];
   assign rsp_tdata  = word_ff[ROUND_COUNT-1];

   // a held first stage keeps its word
   `SPN_ASSERT_NEXT(a_first_stage_hold, clock, reset,
      valid_ff[0] && !stage_ready[0], valid_ff[0] && $stable(word_ff[0]))
   // the first stage fills only from an offered input item
   `SPN_ASSERT_IMPL(a_fill_from_input, clock, reset, $rose(valid_ff[0]), $past(req_tvalid))
   // reset leaves no result on the output
   `SPN_ASSERT_AFTER_RESET(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule

/* dv/spn_cipher_32bit_encrypt_unit_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SPN cipher 32-bit encrypt unit testbench
// Streams plaintext items through the encryptor under several keys and
// checks every ciphertext item against an in-bench cipher predictor.
// ---------------------------------------------------------------------------
module spn_cipher_32bit_encrypt_unit_tb;

   localparam int ROUNDS      = 16;    // rounds built into the unit
   localparam int STALL_LIMIT = 2000;  // cycles with no handshake before giving up
   localparam int LONG_HOLD   = 120;   // receiver hold-off, well past pipe depth
   localparam int BURST_ITEMS = 60;    // back-to-back items offered during the hold
   localparam int PHASE_ITEMS = 180;   // random items per key setting
   localparam int PHASES      = 6;

   // round shifts come from primes 5, 7, 11, ..., each taken mod 32
   localparam logic [6:0] ROUND_SHIFT_PRIMES [23] = '{
      7'd5,  7'd7,  7'd11, 7'd13, 7'd17, 7'd19, 7'd23, 7'd29,
      7'd31, 7'd37, 7'd41, 7'd43, 7'd47, 7'd53, 7'd59, 7'd61,
      7'd67, 7'd71, 7'd73, 7'd79, 7'd83, 7'd89, 7'd97
   };

   // nibble j of the output comes from nibble j of the row the input nibble picks
   localparam spn_pkg::word_type SBOX_ROWS [16] = '{
      32'h673b2a77, 32'h514af6b1, 32'hb2cf4e6f, 32'hdc958843,
      32'h20d0a204, 32'h95786052, 32'h795c3fe5, 32'he8b3e72c,
      32'haef914fe, 32'h4d227ba0, 32'h3fe70c96, 32'hf48693db,
      32'h0a6dbd1a, 32'hcb01c1cd, 32'h13a4d988, 32'h861e5539
   };

   // directed plaintexts: extremes, single bits, checkerboards and every
   // nibble value in every position at once
   localparam spn_pkg::word_type DIRECTED_WORDS [24] = '{
      32'h00000000, 32'hffffffff, 32'h00000001, 32'h80000000,
      32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 32'hf0f0f0f0,
      32'h12345678, 32'h11111111, 32'h22222222, 32'h33333333,
      32'h44444444, 32'h55555554, 32'h66666666, 32'h77777777,
      32'h88888888, 32'h99999999, 32'hbbbbbbbb, 32'hcccccccc,
      32'hdddddddd, 32'heeeeeeee, 32'h7fffffff, 32'hfffffffe
   };

   // -----------------------------------------------------------------------
   // Cipher predictor and ciphertext queue
   // -----------------------------------------------------------------------
   class cipher_scoreboard;
      spn_pkg::word_type key = '0;
      spn_pkg::word_type ciphertext_q[$];
      int                fails = 0;

      function spn_pkg::word_type rotate_key(int unsigned amount);
         int unsigned s;
         s = amount % 32;
         if (s == 0) return key;
         return (key >> s) | (key << (32 - s));
      endfunction

      function spn_pkg::word_type nibble_layer(spn_pkg::word_type v);
         spn_pkg::word_type out_word;
         spn_pkg::word_type row;
         out_word = '0;
         for (int j = 0; j < 8; j++) begin
            row = SBOX_ROWS[v[4*j +: 4]];
            out_word[4*j +: 4] = row[4*j +: 4];
         end
         return out_word;
      endfunction

      function spn_pkg::word_type bit_shuffle(spn_pkg::word_type v);
         return (v & 32'h11111111)          |
                ((v & 32'h20200000) >> 2)   | ((v & 32'h08080800) << 2)  |
                ((v & 32'h04040000) >> 4)   | ((v & 32'h00004000) << 4)  |
                ((v & 32'h00000020) << 5)   | ((v & 32'h40000000) >> 7)  |
                ((v & 32'h00008200) >> 8)   | ((v & 32'h00800002) << 8)  |
                ((v & 32'h00020000) >> 15)  | ((v & 32'h00000004) << 15) |
                ((v & 32'h80400000) >> 16)  | ((v & 32'h00000080) << 19) |
                ((v & 32'h02000000) >> 22)  | ((v & 32'h00000008) << 22) |
                ((v & 32'h00000040) << 24);
      endfunction

      function spn_pkg::word_type encrypt(spn_pkg::word_type plain);
         spn_pkg::word_type w;
         w = plain;
         for (int r = 0; r < ROUNDS; r++) begin
            // round key is always rotated from the raw key, never chained
            w = w ^ rotate_key(ROUND_SHIFT_PRIMES[r % 23]);
            w = nibble_layer(w);
            w = bit_shuffle(w);
         end
         return w;
      endfunction

      function void note_plaintext(spn_pkg::word_type plain);
         ciphertext_q.push_back(encrypt(plain));
      endfunction

      function void check_ciphertext(spn_pkg::word_type got);
         spn_pkg::word_type want;
         if (ciphertext_q.size() == 0) begin
            $error("ciphertext: none expected, actual %h", got);
            fails++;
         end else begin
            want = ciphertext_q.pop_front();
            if (got !== want) begin
               $error("ciphertext: expected %h actual %h", want, got);
               fails++;
            end
         end
      endfunction

      function int pending();
         return ciphertext_q.size();
      endfunction
   endclass

   // -----------------------------------------------------------------------
   // DUT and its stimulus nets; every input known from time zero
   // -----------------------------------------------------------------------
   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   spn_pkg::word_type req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   spn_pkg::word_type rsp_tdata;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   spn_pkg::word_type csr_data   = '0;

   cipher_scoreboard board = new;

   bit tx_idling   = 1'b0;   // sender inserts gaps
   bit rx_idling   = 1'b0;   // receiver inserts stalls
   bit hold_req    = 1'b0;   // ask the receiver for one long hold-off
   int idle_cycles = 0;

   spn_cipher_32bit_encrypt_unit #(
      .ROUND_COUNT (ROUNDS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // mostly no gap, often a short one, now and then a long one
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // plain random words plus a share of sparse and dense patterns
   function automatic spn_pkg::word_type random_plaintext();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: begin
            return ($urandom_range(0, 1) != 0) ? 32'hffffffff : 32'h00000000;
         end
         1: begin
            return 32'h1 << $urandom_range(0, 31);
         end
         2: begin
            return ~(32'h1 << $urandom_range(0, 31));
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // -----------------------------------------------------------------------
   // Monitors: sample handshakes at the edge, before any driver update lands
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         // key writes only happen with the pipe empty, so order here is safe
         if (csr_valid && csr_ready) board.key = csr_data;
         if (req_tvalid && req_tready) board.note_plaintext(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_ciphertext(rsp_tdata);

         // watchdog: any handshake counts as progress
         if ((csr_valid && csr_ready) || (req_tvalid && req_tready) ||
             (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // -----------------------------------------------------------------------
   // Receiver: ready bursts with random stalls, plus the long hold-off
   // -----------------------------------------------------------------------
   initial begin : receiver
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            // long hold: pipe fills and req_tready has to drop
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_req = 1'b0;
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         stall = rx_idling ? idle_gap() : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // -----------------------------------------------------------------------
   // Sender tasks
   // -----------------------------------------------------------------------
   // offer one item; valid stays high into the next item unless a gap follows
   task automatic send_plain(input spn_pkg::word_type plain, input int gap);
      req_tvalid <= 1'b1;
      req_tdata  <= plain;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and wait for every outstanding ciphertext
   task automatic go_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() > 0) @(posedge clock);
   endtask

   // key changes only with the pipe drained and settled
   task automatic write_key(input spn_pkg::word_type k);
      go_quiet();
      repeat (ROUNDS + 4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= k;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // -----------------------------------------------------------------------
   // Main sequence
   // -----------------------------------------------------------------------
   initial begin : stimulus
      spn_pkg::word_type key_plan [PHASES];

      // extremes first, then single edge bits, random keys, and zero again
      key_plan[0] = 32'hffffffff;
      key_plan[1] = 32'h00000001;
      key_plan[2] = $urandom;
      key_plan[3] = 32'h80000000;
      key_plan[4] = $urandom;
      key_plan[5] = 32'h00000000;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed items under the reset key, no idling on either side
      foreach (DIRECTED_WORDS[i]) send_plain(DIRECTED_WORDS[i], 0);

      for (int ph = 0; ph < PHASES; ph++) begin
         write_key(key_plan[ph]);
         // phase 0 runs flat out; phase 3 stalls only on the send side
         tx_idling = (ph != 0);
         rx_idling = (ph != 0) && (ph != 3);

         if (ph == 2) begin
            // back-to-back offers against a receiver that holds off
            hold_req = 1'b1;
            repeat (BURST_ITEMS) send_plain(random_plaintext(), 0);
         end

         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_plain(random_plaintext(), tx_idling ? idle_gap() : 0);
            // sender pause mid-phase until the pipe has drained
            if (i == PHASE_ITEMS / 2) go_quiet();
         end
      end

      go_quiet();
      // catch anything extra trailing out of the pipe
      repeat (ROUNDS + 8) @(posedge clock);

      if (board.fails == 0 && board.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/spn_pkg.sv
src/spn_cipher_32bit_encrypt_unit.sv
dv/spn_cipher_32bit_encrypt_unit_tb.sv
